// ===== rtl/cis_pkg.sv =====
// cis_pkg: shared types, character codes and classifiers for the C identifier scanner.
// Used by cis_scan_step and c_identifier_scanner; depends on nothing else.
package cis_pkg;

   typedef enum logic [3:0] {
      MODE_NEUTRAL    = 4'd0,
      MODE_TOKEN      = 4'd1,
      MODE_STRING     = 4'd2,
      MODE_STRING_ESC = 4'd3,
      MODE_CHAR       = 4'd4,
      MODE_CHAR_ESC   = 4'd5,
      MODE_SLASH      = 4'd6,
      MODE_BLOCK      = 4'd7,
      MODE_BLOCK_STAR = 4'd8,
      MODE_LINE       = 4'd9
   } mode_type;

   typedef enum logic [1:0] {
      WARN_NONE   = 2'd0,
      WARN_STRING = 2'd1,
      WARN_CHAR   = 2'd2
   } warn_type;

   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_byte_valid;
      logic       token_begins;
      logic       token_ends;
      warn_type   warning_code;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

// ===== rtl/c_identifier_scanner.sv =====
// c_identifier_scanner: top level; streams C source bytes in, identifier bytes out.
// Depends on cis_pkg and cis_scan_step.
//
//   channel | dir | payload                                         | accept
//   req_    | in  | tdata[7:0] source_byte, tlast end_of_input      | tvalid & tready
//   rsp_    | out | tdata[7:0] token_byte, tuser flags + warning    | tvalid & tready
//
// One request in, one response out. The request is
// held in an input register, the scanner step runs between it and the
// response register, and the mode register updates when the response loads.
// Throughput is one request per cycle while rsp_tready does not stall; the
// mode register feedback through the step logic is the only loop.
// Reset (synchronous, active high) empties both registers and sets the
// scanner to neutral. A stalled rsp_tready holds the response; one more
// request is still taken into the input register before req_tready drops.
module c_identifier_scanner (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] source_byte
   input  logic       req_tlast,   // end_of_input
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_byte
   output logic [4:0] rsp_tuser    // [0] token_byte_valid, [1] token_begins,
                                   // [2] token_ends, [4:3] warning_code
);

   // input register
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_eoi_ff;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   cis_pkg::result_type rsp_result_ff;

   // scanner mode
   cis_pkg::mode_type   mode_ff;
   cis_pkg::mode_type   mode_in;

   cis_pkg::mode_type   step_mode;
   cis_pkg::result_type step_result;
   logic                advance;
   logic                req_accept;

   cis_scan_step u_step (
      .mode         (mode_ff),
      .source_byte  (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .next_mode    (step_mode),
      .result       (step_result)
   );

   // input stage moves on when the response register is empty or draining
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      mode_in      = mode_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            mode_in = step_mode;
         end
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= cis_pkg::MODE_NEUTRAL;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tlast;
      end
      if (advance && in_valid_ff) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_result_ff.token_byte;
   assign rsp_tuser  = {rsp_result_ff.warning_code,
                        rsp_result_ff.token_ends,
                        rsp_result_ff.token_begins,
                        rsp_result_ff.token_byte_valid};

endmodule

// ===== rtl/cis_scan_step.sv =====
// cis_scan_step: next-mode and result logic for one source byte.
// Purely combinational; uses cis_pkg types and classifiers.
module cis_scan_step (
   input  cis_pkg::mode_type   mode,
   input  logic [7:0]          source_byte,
   input  logic                end_of_input,
   output cis_pkg::mode_type   next_mode,
   output cis_pkg::result_type result
);

   logic letter;
   logic digit;

   assign letter = cis_pkg::is_letter(source_byte);
   assign digit  = cis_pkg::is_digit(source_byte);

   always_comb begin
      next_mode = mode;
      result    = '{token_byte: 8'd0, token_byte_valid: 1'b0, token_begins: 1'b0,
                    token_ends: 1'b0, warning_code: cis_pkg::WARN_NONE};
      if (end_of_input) begin
         result.token_ends = (mode == cis_pkg::MODE_TOKEN);
         next_mode         = cis_pkg::MODE_NEUTRAL;
      end else begin
         case (mode)
            cis_pkg::MODE_NEUTRAL: begin
               if (letter || (source_byte == cis_pkg::CH_UNDERSCORE)) begin
                  next_mode               = cis_pkg::MODE_TOKEN;
                  result.token_byte       = source_byte;
                  result.token_byte_valid = 1'b1;
                  result.token_begins     = 1'b1;
               end else if (source_byte == cis_pkg::CH_SLASH) begin
                  next_mode = cis_pkg::MODE_SLASH;
               end else if (source_byte == cis_pkg::CH_DQUOTE) begin
                  next_mode = cis_pkg::MODE_STRING;
               end else if (source_byte == cis_pkg::CH_SQUOTE) begin
                  next_mode = cis_pkg::MODE_CHAR;
               end
            end
            cis_pkg::MODE_TOKEN: begin
               if (letter || digit || (source_byte == cis_pkg::CH_UNDERSCORE)) begin
                  result.token_byte       = source_byte;
                  result.token_byte_valid = 1'b1;
               end else begin
                  // terminator is consumed, not rescanned
                  result.token_ends = 1'b1;
                  next_mode         = cis_pkg::MODE_NEUTRAL;
               end
            end
            cis_pkg::MODE_STRING: begin
               if (source_byte == cis_pkg::CH_BACKSLASH) begin
                  next_mode = cis_pkg::MODE_STRING_ESC;
               end else if (source_byte == cis_pkg::CH_DQUOTE) begin
                  next_mode = cis_pkg::MODE_NEUTRAL;
               end else if (source_byte == cis_pkg::CH_NEWLINE) begin
                  next_mode           = cis_pkg::MODE_NEUTRAL;
                  result.warning_code = cis_pkg::WARN_STRING;
               end
            end
            cis_pkg::MODE_STRING_ESC: begin
               next_mode = cis_pkg::MODE_STRING;
            end
            cis_pkg::MODE_CHAR: begin
               if (source_byte == cis_pkg::CH_BACKSLASH) begin
                  next_mode = cis_pkg::MODE_CHAR_ESC;
               end else if (source_byte == cis_pkg::CH_SQUOTE) begin
                  next_mode = cis_pkg::MODE_NEUTRAL;
               end else if (source_byte == cis_pkg::CH_NEWLINE) begin
                  next_mode           = cis_pkg::MODE_NEUTRAL;
                  result.warning_code = cis_pkg::WARN_CHAR;
               end
            end
            cis_pkg::MODE_CHAR_ESC: begin
               next_mode = cis_pkg::MODE_CHAR;
            end
            cis_pkg::MODE_SLASH: begin
               if (source_byte == cis_pkg::CH_STAR) begin
                  next_mode = cis_pkg::MODE_BLOCK;
               end else if (source_byte == cis_pkg::CH_SLASH) begin
                  next_mode = cis_pkg::MODE_LINE;
               end else if (letter) begin
                  // underscore does not start a token here
                  next_mode               = cis_pkg::MODE_TOKEN;
                  result.token_byte       = source_byte;
                  result.token_byte_valid = 1'b1;
                  result.token_begins     = 1'b1;
               end else begin
                  next_mode = cis_pkg::MODE_NEUTRAL;
               end
            end
            cis_pkg::MODE_BLOCK: begin
               if (source_byte == cis_pkg::CH_STAR) begin
                  next_mode = cis_pkg::MODE_BLOCK_STAR;
               end
            end
            cis_pkg::MODE_BLOCK_STAR: begin
               if (source_byte == cis_pkg::CH_SLASH) begin
                  next_mode = cis_pkg::MODE_NEUTRAL;
               end else if (source_byte != cis_pkg::CH_STAR) begin
                  next_mode = cis_pkg::MODE_BLOCK;
               end
            end
            cis_pkg::MODE_LINE: begin
               if (source_byte == cis_pkg::CH_NEWLINE) begin
                  next_mode = cis_pkg::MODE_NEUTRAL;
               end
            end
            default: begin
               next_mode = cis_pkg::MODE_NEUTRAL;
            end
         endcase
      end
   end

endmodule

// ===== tb/sv/c_identifier_scanner_tb.sv =====
// c_identifier_scanner_tb: self-checking bench for the C identifier scanner.
// Needs cis_pkg (types, character codes) and the c_identifier_scanner RTL.
// Runs directed source fragments and then random C-like byte streams.
module c_identifier_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cis_pkg::*;

   // ------------------------------------------------------------------
   // Clock, reset and DUT ports; every input has a known value at time 0
   // ------------------------------------------------------------------
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] source_byte
   logic       req_tlast  = 1'b0;    // end_of_input
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] token_byte
   logic [4:0] rsp_tuser;            // [0] token_byte_valid, [1] token_begins,
                                     // [2] token_ends, [4:3] warning_code

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   c_identifier_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   mode_type   shadow_mode = MODE_NEUTRAL;   // scanner mode as the bench sees it
   result_type predicted_results[$];         // one entry per accepted request
   bit         quiet       = 1'b0;           // set for the tail: no idles, no stalls
   int         stall_left  = 0;
   int         failures    = 0;
   int         items_sent  = 0;
   int         idents_seen = 0;
   int         warns_seen  = 0;
   int         ends_sent   = 0;

   // ------------------------------------------------------------------
   // Scanner prediction
   // ------------------------------------------------------------------
   function automatic logic alpha(input logic [7:0] c);
      // ASCII letters only; bytes 128..255 never qualify
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic numeral(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // Advances shadow_mode by one request and returns the response it causes.
   // A byte that closes an identifier is eaten here, never rescanned.
   function automatic result_type scan_byte(input logic [7:0] c, input logic eoi);
      result_type r;
      r = '0;
      if (eoi) begin
         // end marker closes an open identifier, then back to neutral
         r.token_ends = (shadow_mode == MODE_TOKEN);
         shadow_mode  = MODE_NEUTRAL;
         return r;
      end
      case (shadow_mode)
         MODE_NEUTRAL: begin
            if (alpha(c) || c == CH_UNDERSCORE) begin
               shadow_mode        = MODE_TOKEN;
               r.token_byte       = c;
               r.token_byte_valid = 1'b1;
               r.token_begins     = 1'b1;
            end else if (c == CH_SLASH) begin
               shadow_mode = MODE_SLASH;
            end else if (c == CH_DQUOTE) begin
               shadow_mode = MODE_STRING;
            end else if (c == CH_SQUOTE) begin
               shadow_mode = MODE_CHAR;
            end
         end
         MODE_TOKEN: begin
            if (alpha(c) || numeral(c) || c == CH_UNDERSCORE) begin
               r.token_byte       = c;
               r.token_byte_valid = 1'b1;
            end else begin
               r.token_ends = 1'b1;
               shadow_mode  = MODE_NEUTRAL;
            end
         end
         MODE_STRING: begin
            if (c == CH_BACKSLASH) begin
               shadow_mode = MODE_STRING_ESC;
            end else if (c == CH_DQUOTE) begin
               shadow_mode = MODE_NEUTRAL;
            end else if (c == CH_NEWLINE) begin
               shadow_mode    = MODE_NEUTRAL;
               r.warning_code = WARN_STRING;
            end
         end
         MODE_STRING_ESC: shadow_mode = MODE_STRING;
         MODE_CHAR: begin
            if (c == CH_BACKSLASH) begin
               shadow_mode = MODE_CHAR_ESC;
            end else if (c == CH_SQUOTE) begin
               shadow_mode = MODE_NEUTRAL;
            end else if (c == CH_NEWLINE) begin
               shadow_mode    = MODE_NEUTRAL;
               r.warning_code = WARN_CHAR;
            end
         end
         MODE_CHAR_ESC: shadow_mode = MODE_CHAR;
         MODE_SLASH: begin
            // after a slash only a letter opens an identifier, not '_'
            if (c == CH_STAR) begin
               shadow_mode = MODE_BLOCK;
            end else if (c == CH_SLASH) begin
               shadow_mode = MODE_LINE;
            end else if (alpha(c)) begin
               shadow_mode        = MODE_TOKEN;
               r.token_byte       = c;
               r.token_byte_valid = 1'b1;
               r.token_begins     = 1'b1;
            end else begin
               shadow_mode = MODE_NEUTRAL;
            end
         end
         MODE_BLOCK: begin
            if (c == CH_STAR) shadow_mode = MODE_BLOCK_STAR;
         end
         MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) begin
               shadow_mode = MODE_NEUTRAL;
            end else if (c != CH_STAR) begin
               shadow_mode = MODE_BLOCK;
            end
         end
         MODE_LINE: begin
            if (c == CH_NEWLINE) shadow_mode = MODE_NEUTRAL;
         end
         default: shadow_mode = MODE_NEUTRAL;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: random idle burst, then hold the request until taken.
   // Prediction happens at the accepting edge, so queue order matches.
   // ------------------------------------------------------------------
   task automatic send_item(input logic [7:0] b, input logic eoi);
      int         gap;
      result_type r;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = scan_byte(b, eoi);
      predicted_results.push_back(r);
      items_sent++;
      if (r.token_begins) idents_seen++;
      if (r.warning_code != WARN_NONE) warns_seen++;
      if (eoi) ends_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall bursts, then a field-by-field check
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_results.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual tdata %h tuser %h",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = predicted_results.pop_front();
            check_field("token_byte",       32'(want.token_byte),       32'(rsp_tdata));
            check_field("token_byte_valid", 32'(want.token_byte_valid), 32'(rsp_tuser[0]));
            check_field("token_begins",     32'(want.token_begins),     32'(rsp_tuser[1]));
            check_field("token_ends",       32'(want.token_ends),       32'(rsp_tuser[2]));
            check_field("warning_code",     32'(want.warning_code),     32'(rsp_tuser[4:3]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Random stream helpers
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] rand_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                  : 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   function automatic logic [7:0] rand_ident_char();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(8'h30, 8'h39));
         1:       return CH_UNDERSCORE;
         default: return rand_letter();
      endcase
   endfunction

   // Quoted literal with random escapes; about one in five is cut by a newline.
   task automatic send_literal(input logic [7:0] quote);
      int n;
      send_item(quote, 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) begin
         if ($urandom_range(0, 5) == 0) begin
            send_item(CH_BACKSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);   // escaped byte, anything
         end else begin
            send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         end
      end
      send_item(($urandom_range(0, 4) == 0) ? CH_NEWLINE : quote, 1'b0);
   endtask

   // One C-like construct: mostly well-formed, with some noise mixed in.
   task automatic send_random_construct();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            // identifier and a byte after it, usually one that ends it (and is swallowed)
            send_item(($urandom_range(0, 3) == 0) ? CH_UNDERSCORE : rand_letter(), 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) send_item(rand_ident_char(), 1'b0);
            if ($urandom_range(0, 4) == 0)
               send_item(8'($urandom_range(0, 255)), 1'b0);
            else
               send_item(pick(" \t\n;,()+-*=[]{}<>!&|.#/\"'"), 1'b0);
         end
         3: begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(pick(" \t\n;,(){}=+-<>0123456789"), 1'b0);
         end
         4: send_literal(CH_DQUOTE);
         5: send_literal(CH_SQUOTE);
         6: begin
            send_text("/*");
            n = $urandom_range(0, 8);
            repeat (n) send_item(pick("ab_ **\n/\"'"), 1'b0);
            if ($urandom_range(0, 1) == 0) begin
               send_text("*/");
            end else begin
               send_text("**/");
            end
         end
         7: begin
            send_text("//");
            n = $urandom_range(0, 8);
            repeat (n) send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
            send_item(CH_NEWLINE, 1'b0);
         end
         8: begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
         end
         default: begin
            if ($urandom_range(0, 2) == 0) begin
               // end marker; the byte it carries must be ignored
               send_item(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               send_item(CH_SLASH, 1'b0);
               send_item(pick("_9aZ*/ \"'"), 1'b0);
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_identifiers();
      send_text("_a9");
      send_item(8'hFF, 1'b0);     // high byte is no letter: closes the identifier
      send_text("/Zq/_");         // letter after slash opens; '/' closing is eaten
      send_item(8'h00, 1'b1);     // end marker closes the open identifier
   endtask

   task automatic test_literals();
      send_text("\"\\\"\n");      // escaped quote, then newline warns (string)
      send_text("'\\'\n");        // same for a character literal
   endtask

   task automatic test_comments();
      send_text("/**a*/");        // star run inside a block comment
      send_text("//\n");
      send_item(8'h80, 1'b1);     // end marker with nothing open
   endtask

   task automatic test_random_source(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) send_random_construct();
   endtask

   // Back-to-back traffic with the receiver always ready.
   task automatic test_quiet_tail(input int count);
      quiet = 1'b1;
      test_random_source(count);
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_identifiers();
      test_literals();
      test_comments();
      test_random_source(420);
      test_quiet_tail(60);
      req_tvalid <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);   // catch any stray response
      $display("Scanned %0d requests (%0d end markers): %0d identifiers opened,",
               items_sent, ends_sent, idents_seen);
      $display("%0d unterminated-literal warnings predicted.", warns_seen);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog, far above the slowest legal run
   initial begin
      #2000000;
      $display("Timeout with %0d responses outstanding", predicted_results.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
